// ===== hw/rtl/pue_pkg.sv =====
// Shared types, constants and functions for the pixel unpack / extreme tracker.
// Used by every module under hw/rtl; has no dependencies of its own.
package pue_pkg;

   // Field and counter widths
   localparam int DIM_BITS       = 16;
   localparam int FRAME_BITS     = 16;
   localparam int RAW_BITS       = 32;
   localparam int PIX_BITS       = 31;
   localparam int OFF_BITS       = 50;
   localparam int BPP_BITS       = 3;
   localparam int BITS_W         = 5;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = (FRAME_BITS + 1 > DIM_BITS) ? FRAME_BITS + 1 : DIM_BITS;

   // frame * height + row
   localparam int BASE_BITS  = FRAME_BITS + DIM_BITS + 1;
   // a dimension times a byte count of at most 4
   localparam int SCALE_BITS = DIM_BITS + BPP_BITS;

   // Register indexes of the write port
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IMAGE_WIDTH     = 3'd0,
      CSR_IMAGE_HEIGHT    = 3'd1,
      CSR_BYTES_PER_PIXEL = 3'd2,
      CSR_BITS_STORED     = 3'd3,
      CSR_HIGH_BIT        = 3'd4,
      CSR_SIGNED_PIXELS   = 3'd5,
      CSR_CURRENT_FRAME   = 3'd6,
      CSR_FRAME_COUNT     = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [DIM_BITS-1:0]   image_width;
      logic [DIM_BITS-1:0]   image_height;
      logic [BPP_BITS-1:0]   bytes_per_pixel;
      logic [BITS_W-1:0]     bits_stored;
      logic [BITS_W-1:0]     high_bit;
      logic                  signed_pixels;
      logic [FRAME_BITS-1:0] current_frame;
      logic [FRAME_BITS:0]   frame_count;
   } cfg_type;

   // Per-stage load strobes of the three-deep pipeline
   typedef struct packed {
      logic load1;
      logic load2;
      logic load3;
   } stage_ctl_type;

   // Byte count: 0 acts as 1, anything above 4 acts as 4
   function automatic logic [BPP_BITS-1:0] clamp_bpp(input logic [BPP_BITS-1:0] bpp);
      logic [BPP_BITS-1:0] res;
      if (bpp == '0) begin
         res = BPP_BITS'(1);
      end else if (bpp > BPP_BITS'(4)) begin
         res = BPP_BITS'(4);
      end else begin
         res = bpp;
      end
      return res;
   endfunction

   // x * bpp as shift-add; bpp is already clamped to 1..4
   function automatic logic [SCALE_BITS-1:0] scale_bpp(input logic [DIM_BITS-1:0] x,
                                                       input logic [BPP_BITS-1:0] bpp);
      logic [SCALE_BITS-1:0] ext;
      ext = SCALE_BITS'(x);
      return (bpp[0] ? ext : '0) + (bpp[1] ? (ext << 1) : '0) + (bpp[2] ? (ext << 2) : '0);
   endfunction

   // Byte select, alignment shift, stored-bit mask and sign handling
   function automatic logic [PIX_BITS-1:0] extract_pixel(
      input logic [RAW_BITS-1:0] raw,
      input logic [BPP_BITS-1:0] bpp,
      input logic [BITS_W-1:0]   bits_stored,
      input logic [BITS_W-1:0]   high_bit,
      input logic                signed_pixels
   );
      logic [RAW_BITS-1:0] byte_mask;
      logic [BITS_W:0]     top_pos;
      logic [BITS_W:0]     stored_ext;
      logic [BITS_W:0]     shift;
      logic [RAW_BITS-1:0] v;
      logic [BITS_W-1:0]   keep;
      logic [RAW_BITS-1:0] keep_mask;
      logic [BITS_W-1:0]   sign_pos;
      // bpp is 1..4, so the byte mask covers 8..32 bits
      byte_mask  = ~({RAW_BITS{1'b1}} << {bpp, 3'b000});
      top_pos    = {1'b0, high_bit} + (BITS_W + 1)'(1);
      stored_ext = {1'b0, bits_stored};
      shift      = (top_pos >= stored_ext) ? (top_pos - stored_ext) : '0;
      v          = (raw & byte_mask) >> shift;
      sign_pos   = bits_stored - BITS_W'(1);
      keep       = signed_pixels ? sign_pos : bits_stored;
      keep_mask  = ~({RAW_BITS{1'b1}} << keep);
      // a negative signed pixel, or a signed pixel with no stored bits, reads as zero
      if (signed_pixels && ((bits_stored == '0) || v[sign_pos])) begin
         v = '0;
      end else begin
         v = v & keep_mask;
      end
      return v[PIX_BITS-1:0];
   endfunction

endpackage

// ===== hw/rtl/pue_csr.sv =====
// Configuration register file of the pixel unpacker.
// Depends on pue_pkg (cfg_type, register index codes).
module pue_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [pue_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [pue_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output pue_pkg::cfg_type                     cfg
);

   pue_pkg::cfg_type cfg_ff;
   pue_pkg::cfg_type cfg_in;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (pue_pkg::csr_index_type'(csr_index))
            pue_pkg::CSR_IMAGE_WIDTH:
               cfg_in.image_width = csr_wdata[pue_pkg::DIM_BITS-1:0];
            pue_pkg::CSR_IMAGE_HEIGHT:
               cfg_in.image_height = csr_wdata[pue_pkg::DIM_BITS-1:0];
            pue_pkg::CSR_BYTES_PER_PIXEL:
               cfg_in.bytes_per_pixel = csr_wdata[pue_pkg::BPP_BITS-1:0];
            pue_pkg::CSR_BITS_STORED:
               cfg_in.bits_stored = csr_wdata[pue_pkg::BITS_W-1:0];
            pue_pkg::CSR_HIGH_BIT:
               cfg_in.high_bit = csr_wdata[pue_pkg::BITS_W-1:0];
            pue_pkg::CSR_SIGNED_PIXELS:
               cfg_in.signed_pixels = csr_wdata[0];
            pue_pkg::CSR_CURRENT_FRAME:
               cfg_in.current_frame = csr_wdata[pue_pkg::FRAME_BITS-1:0];
            pue_pkg::CSR_FRAME_COUNT:
               cfg_in.frame_count = csr_wdata[pue_pkg::FRAME_BITS:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width     <= pue_pkg::DIM_BITS'(1);
         cfg_ff.image_height    <= pue_pkg::DIM_BITS'(1);
         cfg_ff.bytes_per_pixel <= pue_pkg::BPP_BITS'(2);
         cfg_ff.bits_stored     <= pue_pkg::BITS_W'(16);
         cfg_ff.high_bit        <= pue_pkg::BITS_W'(15);
         cfg_ff.signed_pixels   <= 1'b0;
         cfg_ff.current_frame   <= '0;
         cfg_ff.frame_count     <= (pue_pkg::FRAME_BITS + 1)'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/pue_raster.sv =====
// Column / row position counters in raster order, with end-of-frame detect.
// Depends on pue_pkg (cfg_type, DIM_BITS).
module pue_raster (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  pue_pkg::cfg_type               cfg,
   output logic [pue_pkg::DIM_BITS-1:0]   column,
   output logic [pue_pkg::DIM_BITS-1:0]   row,
   output logic                           end_of_frame
);

   logic [pue_pkg::DIM_BITS-1:0] col_ff, col_in;
   logic [pue_pkg::DIM_BITS-1:0] row_ff, row_in;
   logic                         last_col;
   logic                         last_row;

   // A dimension of zero wraps on every beat, same as one
   assign last_col = ({1'b0, col_ff} + (pue_pkg::DIM_BITS + 1)'(1))
                     >= {1'b0, cfg.image_width};
   assign last_row = ({1'b0, row_ff} + (pue_pkg::DIM_BITS + 1)'(1))
                     >= {1'b0, cfg.image_height};

   // Advance position on each accepted beat
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + pue_pkg::DIM_BITS'(1);
         end else begin
            col_in = col_ff + pue_pkg::DIM_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign column       = col_ff;
   assign row          = row_ff;
   assign end_of_frame = last_col && last_row;

endmodule

// ===== hw/rtl/pue_pixel.sv =====
// Pixel extraction and running min / max per frame, three register stages.
// Depends on pue_pkg (cfg_type, stage_ctl_type, extract_pixel, clamp_bpp).
module pue_pixel (
   input  logic                           clock,
   input  logic                           reset,
   input  pue_pkg::stage_ctl_type         ctl,
   input  pue_pkg::cfg_type               cfg,
   input  logic [pue_pkg::RAW_BITS-1:0]   raw_word,
   input  logic                           eof_in,
   output logic [pue_pkg::PIX_BITS-1:0]   pixel_value,
   output logic                           end_of_frame,
   output logic [pue_pkg::PIX_BITS-1:0]   frame_min,
   output logic [pue_pkg::PIX_BITS-1:0]   frame_max
);

   // stage 1: raw input
   logic [pue_pkg::RAW_BITS-1:0] raw1_ff;
   logic                         eof1_ff;
   // stage 2: unpacked pixel and extremes
   logic [pue_pkg::PIX_BITS-1:0] pix2_ff, min2_ff, max2_ff;
   logic                         eof2_ff;
   // stage 3: result register
   logic [pue_pkg::PIX_BITS-1:0] pix3_ff, min3_ff, max3_ff;
   logic                         eof3_ff;
   // running extremes of the current frame
   logic [pue_pkg::PIX_BITS-1:0] run_min_ff, run_min_in;
   logic [pue_pkg::PIX_BITS-1:0] run_max_ff, run_max_in;

   logic [pue_pkg::PIX_BITS-1:0] pix1;
   logic [pue_pkg::PIX_BITS-1:0] new_min;
   logic [pue_pkg::PIX_BITS-1:0] new_max;

   assign pix1 = pue_pkg::extract_pixel(raw1_ff, pue_pkg::clamp_bpp(cfg.bytes_per_pixel),
                                        cfg.bits_stored, cfg.high_bit, cfg.signed_pixels);
   assign new_min = (pix1 < run_min_ff) ? pix1 : run_min_ff;
   assign new_max = (pix1 > run_max_ff) ? pix1 : run_max_ff;

   // Extremes restart after the last pixel of a frame
   always_comb begin
      run_min_in = run_min_ff;
      run_max_in = run_max_ff;
      if (ctl.load2) begin
         run_min_in = eof1_ff ? '1 : new_min;
         run_max_in = eof1_ff ? '0 : new_max;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_min_ff <= '1;
         run_max_ff <= '0;
      end else begin
         run_min_ff <= run_min_in;
         run_max_ff <= run_max_in;
      end
   end

   // Payload stages
   always_ff @(posedge clock) begin
      if (ctl.load1) begin
         raw1_ff <= raw_word;
         eof1_ff <= eof_in;
      end
      if (ctl.load2) begin
         pix2_ff <= pix1;
         eof2_ff <= eof1_ff;
         min2_ff <= eof1_ff ? new_min : '0;
         max2_ff <= eof1_ff ? new_max : '0;
      end
      if (ctl.load3) begin
         pix3_ff <= pix2_ff;
         eof3_ff <= eof2_ff;
         min3_ff <= min2_ff;
         max3_ff <= max2_ff;
      end
   end

   assign pixel_value  = pix3_ff;
   assign end_of_frame = eof3_ff;
   assign frame_min    = min3_ff;
   assign frame_max    = max3_ff;

endmodule

// ===== hw/rtl/pue_offset.sv =====
// Byte offset of each pixel in the multi-frame buffer, plus frame range check.
// Depends on pue_pkg (cfg_type, stage_ctl_type, scale_bpp, clamp_bpp).
module pue_offset (
   input  logic                           clock,
   input  pue_pkg::stage_ctl_type         ctl,
   input  pue_pkg::cfg_type               cfg,
   input  logic [pue_pkg::DIM_BITS-1:0]   column,
   input  logic [pue_pkg::DIM_BITS-1:0]   row,
   output logic [pue_pkg::OFF_BITS-1:0]   byte_offset,
   output logic                           frame_error
);

   logic [pue_pkg::DIM_BITS-1:0]   col1_ff, row1_ff;
   logic [pue_pkg::BASE_BITS-1:0]  base2_ff;
   logic [pue_pkg::SCALE_BITS-1:0] colb2_ff, pitch2_ff;
   logic [pue_pkg::OFF_BITS-1:0]   off3_ff;
   logic                           err3_ff;

   logic [pue_pkg::BPP_BITS-1:0]   bpp;
   logic [pue_pkg::BASE_BITS-1:0]  base1;
   logic [pue_pkg::OFF_BITS-1:0]   off2;

   assign bpp = pue_pkg::clamp_bpp(cfg.bytes_per_pixel);

   // frame * height + row  (16x16 multiply)
   assign base1 = pue_pkg::BASE_BITS'(cfg.current_frame) * pue_pkg::BASE_BITS'(cfg.image_height)
                  + pue_pkg::BASE_BITS'(row1_ff);

   // (frame*height + row) * (width*bpp) + col*bpp, kept to offset width
   assign off2 = pue_pkg::OFF_BITS'(base2_ff) * pue_pkg::OFF_BITS'(pitch2_ff)
                 + pue_pkg::OFF_BITS'(colb2_ff);

   always_ff @(posedge clock) begin
      if (ctl.load1) begin
         col1_ff <= column;
         row1_ff <= row;
      end
      if (ctl.load2) begin
         base2_ff  <= base1;
         colb2_ff  <= pue_pkg::scale_bpp(col1_ff, bpp);
         pitch2_ff <= pue_pkg::scale_bpp(cfg.image_width, bpp);
      end
      if (ctl.load3) begin
         off3_ff <= off2;
         err3_ff <= {1'b0, cfg.current_frame} >= cfg.frame_count;
      end
   end

   assign byte_offset = off3_ff;
   assign frame_error = err3_ff;

endmodule

// ===== hw/rtl/pixel_unpack_extreme_tracker.sv =====
// Pixel unpacker with per-frame min / max: top level.
// Instantiates pue_csr, pue_raster, pue_pixel and pue_offset; uses pue_pkg.
//
// Usage:
//   req_*  : one raw little-endian pixel word per beat, raster order, for the
//            frame selected by the current_frame register.
//   rsp_*  : one result beat per request beat, in order: unpacked pixel, its
//            byte offset in the multi-frame buffer, end-of-frame flag with the
//            frame's min / max on that beat, and the frame range error flag.
//   csr_*  : write-only register port; write only while no beat is in flight.
// Path: an accepted beat passes the input stage, the multiply stage and the
//   result register, in that order, before rsp_valid rises.
//   Throughput: one beat per cycle while rsp_ready does not stall it, set by
//   the three-stage pipeline, whose widest step is one 33x19 multiply.
// Stall: a low rsp_ready holds the result register; earlier stages keep
//   filling, so up to three beats are held before req_ready drops.
// Reset: CSR registers return to their defaults, position counters go to
//   the first pixel, the running min / max are cleared, the pipeline empties.
module pixel_unpack_extreme_tracker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [pue_pkg::RAW_BITS-1:0]         req_raw_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [pue_pkg::PIX_BITS-1:0]         rsp_pixel_value,
   output logic [pue_pkg::OFF_BITS-1:0]         rsp_byte_offset,
   output logic                                 rsp_end_of_frame,
   output logic [pue_pkg::PIX_BITS-1:0]         rsp_frame_min,
   output logic [pue_pkg::PIX_BITS-1:0]         rsp_frame_max,
   output logic                                 rsp_frame_error,
   input  logic                                 csr_write_enable,
   input  logic [pue_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [pue_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   pue_pkg::cfg_type             cfg;
   pue_pkg::stage_ctl_type       ctl;
   logic [pue_pkg::DIM_BITS-1:0] column;
   logic [pue_pkg::DIM_BITS-1:0] row;
   logic                         eof0;

   logic v1_ff, v1_in;
   logic v2_ff, v2_in;
   logic v3_ff, v3_in;
   logic ready2;
   logic ready3;

   // Pipeline flow: a stage loads when it is empty or its contents move on
   assign ready3    = !v3_ff || rsp_ready;
   assign ready2    = !v2_ff || ready3;
   assign req_ready = !v1_ff || ready2;

   assign ctl.load1 = req_valid && req_ready;
   assign ctl.load2 = v1_ff && ready2;
   assign ctl.load3 = v2_ff && ready3;

   assign v1_in = ctl.load1 || (v1_ff && !ctl.load2);
   assign v2_in = ctl.load2 || (v2_ff && !ctl.load3);
   assign v3_in = ctl.load3 || (v3_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   assign rsp_valid = v3_ff;

   pue_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cfg              (cfg)
   );

   pue_raster u_raster (
      .clock        (clock),
      .reset        (reset),
      .accept       (ctl.load1),
      .cfg          (cfg),
      .column       (column),
      .row          (row),
      .end_of_frame (eof0)
   );

   pue_pixel u_pixel (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .cfg          (cfg),
      .raw_word     (req_raw_word),
      .eof_in       (eof0),
      .pixel_value  (rsp_pixel_value),
      .end_of_frame (rsp_end_of_frame),
      .frame_min    (rsp_frame_min),
      .frame_max    (rsp_frame_max)
   );

   pue_offset u_offset (
      .clock       (clock),
      .ctl         (ctl),
      .cfg         (cfg),
      .column      (column),
      .row         (row),
      .byte_offset (rsp_byte_offset),
      .frame_error (rsp_frame_error)
   );

   // Extremes are only reported on the last pixel of a frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_end_of_frame |-> rsp_frame_min == '0 && rsp_frame_max == '0)
      else $error("frame min/max nonzero off end of frame");

   // Every frame has at least one pixel, so min never exceeds max
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_frame |-> rsp_frame_min <= rsp_frame_max)
      else $error("frame min above frame max");

   // A full, stalled pipeline must refuse new beats
   assert property (@(posedge clock) disable iff (reset)
      v1_ff && v2_ff && v3_ff && !rsp_ready |-> !req_ready)
      else $error("request accepted into a full pipeline");

   // An accepted beat always lands in the first stage
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> v1_ff)
      else $error("accepted beat lost at input stage");

endmodule

// ===== bench/tb_pixel_unpack_extreme_tracker.sv =====
// Self-checking bench for pixel_unpack_extreme_tracker: a directed sweep, then random settings.
// Needs pue_pkg and the block's RTL; a built-in predictor of the unpack and the
// frame min / max sets the expected result beats.
module tb_pixel_unpack_extreme_tracker;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS   = 1850;
   localparam int DRAIN_CYCLES   = 8;

   typedef struct packed {
      logic [pue_pkg::PIX_BITS-1:0] pixel_value;
      logic [pue_pkg::OFF_BITS-1:0] byte_offset;
      logic                         end_of_frame;
      logic [pue_pkg::PIX_BITS-1:0] frame_min;
      logic [pue_pkg::PIX_BITS-1:0] frame_max;
      logic                         frame_error;
   } pixel_result_type;

   logic                               clock            = 1'b0;
   logic                               reset            = 1'b1;
   logic                               req_valid        = 1'b0;
   logic                               req_ready;
   logic [pue_pkg::RAW_BITS-1:0]       req_raw_word     = '0;
   logic                               rsp_valid;
   logic                               rsp_ready        = 1'b0;
   logic [pue_pkg::PIX_BITS-1:0]       rsp_pixel_value;
   logic [pue_pkg::OFF_BITS-1:0]       rsp_byte_offset;
   logic                               rsp_end_of_frame;
   logic [pue_pkg::PIX_BITS-1:0]       rsp_frame_min;
   logic [pue_pkg::PIX_BITS-1:0]       rsp_frame_max;
   logic                               rsp_frame_error;
   logic                               csr_write_enable = 1'b0;
   logic [pue_pkg::CSR_INDEX_BITS-1:0] csr_index        = '0;
   logic [pue_pkg::CSR_DATA_BITS-1:0]  csr_wdata        = '0;

   // stimulus words waiting for the driver, and predicted result beats
   logic [pue_pkg::RAW_BITS-1:0] raw_word_queue[$];
   pixel_result_type             predicted_pixels[$];

   // register copy and tracker state of the predictor
   pue_pkg::cfg_type             shadow_regs;
   logic [pue_pkg::DIM_BITS-1:0] col_pos;
   logic [pue_pkg::DIM_BITS-1:0] row_pos;
   logic [pue_pkg::PIX_BITS-1:0] frame_low;
   logic [pue_pkg::PIX_BITS-1:0] frame_high;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int mismatches     = 0;
   int quiet_cycles   = 0;

   pixel_unpack_extreme_tracker DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_raw_word     (req_raw_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_byte_offset  (rsp_byte_offset),
      .rsp_end_of_frame (rsp_end_of_frame),
      .rsp_frame_min    (rsp_frame_min),
      .rsp_frame_max    (rsp_frame_max),
      .rsp_frame_error  (rsp_frame_error),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic logic [31:0] low_bits(input int n);
      return 32'((64'd1 << n) - 64'd1);
   endfunction

   // Predict one result beat and advance the raster position and min / max
   function automatic pixel_result_type unpack_and_track(
      input logic [pue_pkg::RAW_BITS-1:0] raw);
      pixel_result_type res;
      int               eff_bpp;
      int               top_pos;
      int               stored;
      int               shift;
      logic [31:0]      v;
      logic [63:0]      off;
      logic             last_col;
      logic             last_row;
      eff_bpp = int'(shadow_regs.bytes_per_pixel);
      if (eff_bpp == 0) begin
         eff_bpp = 1;
      end else if (eff_bpp > 4) begin
         eff_bpp = 4;
      end
      top_pos = int'(shadow_regs.high_bit) + 1;
      stored  = int'(shadow_regs.bits_stored);
      shift   = (top_pos >= stored) ? top_pos - stored : 0;
      v = (raw & low_bits(eff_bpp * 8)) >> shift;
      // negative signed pixels and signed pixels without stored bits read as zero
      if (shadow_regs.signed_pixels) begin
         if (stored == 0) begin
            v = '0;
         end else if (v[stored-1]) begin
            v = '0;
         end else begin
            v = v & low_bits(stored - 1);
         end
      end else begin
         v = v & low_bits(stored);
      end
      v[31] = 1'b0;

      off = (64'(shadow_regs.current_frame) * 64'(shadow_regs.image_height) + 64'(row_pos))
            * 64'(shadow_regs.image_width);
      off = (off + 64'(col_pos)) * 64'(eff_bpp);

      if (v[pue_pkg::PIX_BITS-1:0] < frame_low) begin
         frame_low = v[pue_pkg::PIX_BITS-1:0];
      end
      if (v[pue_pkg::PIX_BITS-1:0] > frame_high) begin
         frame_high = v[pue_pkg::PIX_BITS-1:0];
      end

      last_col = (int'(col_pos) + 1) >= int'(shadow_regs.image_width);
      last_row = (int'(row_pos) + 1) >= int'(shadow_regs.image_height);

      res.pixel_value  = v[pue_pkg::PIX_BITS-1:0];
      res.byte_offset  = off[pue_pkg::OFF_BITS-1:0];
      res.end_of_frame = last_col && last_row;
      res.frame_min    = res.end_of_frame ? frame_low : '0;
      res.frame_max    = res.end_of_frame ? frame_high : '0;
      res.frame_error  = {1'b0, shadow_regs.current_frame} >= shadow_regs.frame_count;

      // raster advance; a shrunk dimension wraps on the next pixel
      if (last_col) begin
         col_pos = '0;
         row_pos = last_row ? '0 : row_pos + pue_pkg::DIM_BITS'(1);
      end else begin
         col_pos = col_pos + pue_pkg::DIM_BITS'(1);
      end
      if (res.end_of_frame) begin
         frame_low  = '1;
         frame_high = '0;
      end
      return res;
   endfunction

   // Driver: present queued words, predict each accepted beat
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         col_pos    = '0;
         row_pos    = '0;
         frame_low  = '1;
         frame_high = '0;
      end else begin
         if (req_valid && req_ready) begin
            predicted_pixels.push_back(unpack_and_track(req_raw_word));
         end
         if (!req_valid || req_ready) begin
            if (raw_word_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid    <= 1'b1;
               req_raw_word <= raw_word_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endtask

   // Monitor: random back-pressure, compare each result beat with the oldest prediction
   always @(posedge clock) begin
      pixel_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_pixels.size() == 0) begin
               $error("result beat arrived with no prediction pending");
               mismatches++;
            end else begin
               want = predicted_pixels.pop_front();
               check_field("pixel_value", 64'(want.pixel_value), 64'(rsp_pixel_value));
               check_field("byte_offset", 64'(want.byte_offset), 64'(rsp_byte_offset));
               check_field("end_of_frame", 64'(want.end_of_frame), 64'(rsp_end_of_frame));
               check_field("frame_min", 64'(want.frame_min), 64'(rsp_frame_min));
               check_field("frame_max", 64'(want.frame_max), 64'(rsp_frame_max));
               check_field("frame_error", 64'(want.frame_error), 64'(rsp_frame_error));
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_csr(input pue_pkg::csr_index_type idx,
                            input logic [pue_pkg::CSR_DATA_BITS-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= data;
      @(posedge clock);
   endtask

   // Wait for the block to go idle, pick the idle mode, then write every register
   task automatic start_setting(input pue_pkg::cfg_type c, input int idle_mode);
      while (raw_word_queue.size() != 0 || req_valid || predicted_pixels.size() != 0) begin
         @(posedge clock);
      end
      case (idle_mode)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
         default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      write_csr(pue_pkg::CSR_IMAGE_WIDTH, pue_pkg::CSR_DATA_BITS'(c.image_width));
      write_csr(pue_pkg::CSR_IMAGE_HEIGHT, pue_pkg::CSR_DATA_BITS'(c.image_height));
      write_csr(pue_pkg::CSR_BYTES_PER_PIXEL, pue_pkg::CSR_DATA_BITS'(c.bytes_per_pixel));
      write_csr(pue_pkg::CSR_BITS_STORED, pue_pkg::CSR_DATA_BITS'(c.bits_stored));
      write_csr(pue_pkg::CSR_HIGH_BIT, pue_pkg::CSR_DATA_BITS'(c.high_bit));
      write_csr(pue_pkg::CSR_SIGNED_PIXELS, pue_pkg::CSR_DATA_BITS'(c.signed_pixels));
      write_csr(pue_pkg::CSR_CURRENT_FRAME, pue_pkg::CSR_DATA_BITS'(c.current_frame));
      write_csr(pue_pkg::CSR_FRAME_COUNT, pue_pkg::CSR_DATA_BITS'(c.frame_count));
      csr_write_enable <= 1'b0;
      shadow_regs = c;
   endtask

   function automatic pue_pkg::cfg_type make_setting(input int w, input int h, input int bpp,
                                                     input int bits, input int hb,
                                                     input int sgn, input int frame,
                                                     input int count);
      pue_pkg::cfg_type c;
      c.image_width     = pue_pkg::DIM_BITS'(w);
      c.image_height    = pue_pkg::DIM_BITS'(h);
      c.bytes_per_pixel = pue_pkg::BPP_BITS'(bpp);
      c.bits_stored     = pue_pkg::BITS_W'(bits);
      c.high_bit        = pue_pkg::BITS_W'(hb);
      c.signed_pixels   = sgn[0];
      c.current_frame   = pue_pkg::FRAME_BITS'(frame);
      c.frame_count     = (pue_pkg::FRAME_BITS + 1)'(count);
      return c;
   endfunction

   // Mostly small rasters and in-range frames, with the odd extreme or broken value
   function automatic pue_pkg::cfg_type random_setting();
      int w, h, bpp, hb, bits, count, frame;
      case ($urandom_range(0, 9))
         0:       w = 0;
         1:       w = 65535;
         default: w = $urandom_range(1, 12);
      endcase
      case ($urandom_range(0, 9))
         0:       h = 0;
         1:       h = 65535;
         default: h = $urandom_range(1, 6);
      endcase
      bpp  = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(0, 7);
      hb   = $urandom_range(0, 31);
      bits = $urandom_range(0, 1) ? $urandom_range(0, (hb + 1 > 31) ? 31 : hb + 1)
                                  : $urandom_range(0, 31);
      case ($urandom_range(0, 5))
         0:       count = 1;
         1:       count = 65536;
         default: count = $urandom_range(1, 20);
      endcase
      frame = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                          : $urandom_range(0, count - 1);
      return make_setting(w, h, bpp, bits, hb, $urandom_range(0, 1), frame, count);
   endfunction

   function automatic logic [pue_pkg::RAW_BITS-1:0] random_raw_word();
      logic [pue_pkg::RAW_BITS-1:0] w;
      case ($urandom_range(0, 3))
         0:       w = $urandom;
         1:       w = $urandom_range(0, 255);
         2:       w = $urandom | 32'h8080_8080;
         default: w = ~(32'd1 << $urandom_range(0, 31));
      endcase
      return w;
   endfunction

   // Stimulus: reset, directed sweep, random settings, drain and verdict
   initial begin
      int random_items;
      int phase_index;
      int n;
      random_items = 0;
      phase_index  = 0;
      shadow_regs  = make_setting(1, 1, 2, 16, 15, 0, 0, 1);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults after reset, every pixel closes a frame
      raw_word_queue.push_back(32'h0000_0000);
      raw_word_queue.push_back(32'hFFFF_FFFF);
      raw_word_queue.push_back(32'h0000_FFFF);
      raw_word_queue.push_back(32'h0000_8000);

      // zero byte count, zero stored bits signed, zero dimensions
      start_setting(make_setting(0, 0, 0, 0, 0, 1, 0, 1), 0);
      raw_word_queue.push_back(32'hFFFF_FFFF);
      raw_word_queue.push_back(32'h0000_0001);

      // byte count above 4, widest fields, last frame of the largest buffer
      start_setting(make_setting(3, 1, 7, 31, 31, 0, 65535, 65536), 0);
      raw_word_queue.push_back(32'hFFFF_FFFF);
      raw_word_queue.push_back(32'h7FFF_FFFF);
      raw_word_queue.push_back(32'h8000_0000);

      // high bit below the stored bits, no shift
      start_setting(make_setting(2, 1, 4, 12, 3, 0, 0, 1), 0);
      raw_word_queue.push_back(32'h0000_0FFF);
      raw_word_queue.push_back(32'h1234_5678);

      // one signed stored bit always reads zero
      start_setting(make_setting(1, 3, 1, 1, 0, 1, 0, 1), 0);
      raw_word_queue.push_back(32'h0000_0001);
      raw_word_queue.push_back(32'h0000_0000);
      raw_word_queue.push_back(32'h0000_00FF);

      // signed bytes, negative values read zero
      start_setting(make_setting(2, 2, 1, 8, 7, 1, 0, 1), 0);
      raw_word_queue.push_back(32'h0000_0080);
      raw_word_queue.push_back(32'h0000_007F);
      raw_word_queue.push_back(32'h0000_0001);
      raw_word_queue.push_back(32'hFFFF_FFFF);

      // frame index not below the frame count
      start_setting(make_setting(2, 2, 3, 20, 23, 0, 5, 3), 0);
      repeat (4) raw_word_queue.push_back($urandom);

      // largest dimensions and frame, largest offsets
      start_setting(make_setting(65535, 65535, 4, 16, 15, 0, 65535, 1), 0);
      raw_word_queue.push_back(32'hDEAD_BEEF);
      raw_word_queue.push_back(32'h0000_0000);

      // random settings, idle modes in rotation
      while (random_items < RANDOM_ITEMS) begin
         start_setting(random_setting(), phase_index % 4);
         n = $urandom_range(40, 110);
         repeat (n) raw_word_queue.push_back(random_raw_word());
         random_items += n;
         phase_index++;
      end

      while (raw_word_queue.size() != 0 || req_valid || predicted_pixels.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && predicted_pixels.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
